FILE: sv/assert_macros.svh
// assertion macros shared by the blitter modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// consequence must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/pfb_pkg.sv
// types, constants and helpers of the pixel format blitter
`default_nettype none

package pfb_pkg;

  localparam int CFG_DIM_W        = 12;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 12;
  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int COORD_BITS_DEF   = 12;
  localparam int PAL_INDEX_W      = 8;
  localparam int PAL_COLOR_W      = 24;
  localparam int ADDR_W           = 24;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd4;

  localparam logic OP_PIXEL   = 1'b0;
  localparam logic OP_PAL_WR  = 1'b1;

  localparam logic [15:0] RGB565_R_MASK = 16'hF800;
  localparam logic [15:0] RGB565_G_MASK = 16'h07E0;
  localparam logic [15:0] RGB565_B_MASK = 16'h001F;
  localparam logic [7:0]  ALPHA_OPAQUE  = 8'hff;

  typedef enum logic [1:0] {
    MODE_PAL8     = 2'd0,
    MODE_RGB565   = 2'd1,
    MODE_RGB888   = 2'd2,
    MODE_RGBA8888 = 2'd3
  } pix_mode_e;

  typedef struct packed {
    pix_mode_e              pixel_mode;
    logic [CFG_DIM_W-1:0]   src_width;
    logic [CFG_DIM_W-1:0]   src_height;
    logic [CFG_DIM_W-1:0]   dst_width;
    logic [CFG_DIM_W-1:0]   dst_height;
  } cfg_t;

  typedef struct packed {
    logic                   op;
    logic [31:0]            pixel_data;
    logic [PAL_INDEX_W-1:0] palette_index;
    logic [PAL_COLOR_W-1:0] palette_color;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0]      dest_addr;
    logic [31:0]            rgba_color;
    logic                   frame_last;
  } out_t;

  // position flags of the current pixel
  typedef struct packed {
    logic visible;
    logic last;
  } raster_t;

  // width of a centered coordinate and of the compares around it
  function automatic int xy_width(int cb);
    return ((cb > CFG_DIM_W) ? cb : CFG_DIM_W) + 1;
  endfunction

endpackage

`default_nettype wire

FILE: sv/pfb_ram.sv
// generic single write port ram with registered read
`default_nettype none

module pfb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: sv/pfb_palette.sv
// color palette: ram plus per-entry valid bits so unwritten entries read zero
`default_nettype none
`include "assert_macros.svh"

module pfb_palette import pfb_pkg::*; #(
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   wr_en_i,
  input  wire logic [PAL_INDEX_W-1:0] wr_index_i,
  input  wire logic [PAL_COLOR_W-1:0] wr_color_i,
  input  wire logic                   rd_en_i,
  input  wire logic [PAL_INDEX_W-1:0] rd_index_i,
  output logic      [31:0]            color_o
);

  localparam int IW = $clog2(PALETTE_DEPTH);

  logic [PALETTE_DEPTH-1:0] vld_q, vld_d;
  logic                     hit_q, hit_d;
  logic                     wr_ok, rd_ok;
  logic [IW-1:0]            wr_idx, rd_idx;
  logic [PAL_COLOR_W-1:0]   ram_rdata;

  // indexes at or above the depth are dropped on write and read as zero
  assign wr_ok  = wr_en_i && ({1'b0, wr_index_i} < (PAL_INDEX_W + 1)'(PALETTE_DEPTH));
  assign rd_ok  = {1'b0, rd_index_i} < (PAL_INDEX_W + 1)'(PALETTE_DEPTH);
  assign wr_idx = wr_index_i[IW-1:0];
  assign rd_idx = rd_index_i[IW-1:0];

  always_comb begin
    vld_d = vld_q;
    if (wr_ok) begin
      vld_d[wr_idx] = 1'b1;
    end
    hit_d = hit_q;
    if (rd_en_i) begin
      hit_d = rd_ok && vld_q[rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      hit_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      hit_q <= hit_d;
    end
  end

  pfb_ram #(
    .WIDTH (PAL_COLOR_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_ok),
    .waddr_i (wr_idx),
    .wdata_i (wr_color_i),
    .re_i    (rd_en_i),
    .raddr_i (rd_idx),
    .rdata_o (ram_rdata)
  );

  assign color_o = hit_q ? {ALPHA_OPAQUE, ram_rdata} : 32'd0;

  `ASSERT_NEXT(a_wr_sets_valid, wr_ok, vld_q[$past(wr_idx)], "palette write left entry invalid")

endmodule

`default_nettype wire

FILE: sv/pfb_raster.sv
// raster counters, visibility window and centered destination coordinates
`default_nettype none
`include "assert_macros.svh"

module pfb_raster import pfb_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire cfg_t                             cfg_i,
  input  wire logic                             cfg_wr_i,
  input  wire logic                             step_i,
  output raster_t                               pos_o,
  output logic      [xy_width(COORD_BITS)-1:0] x_o,
  output logic      [xy_width(COORD_BITS)-1:0] y_o
);

  localparam int XW = xy_width(COORD_BITS);

  logic [COORD_BITS-1:0] col_q, col_d, row_q, row_d;
  logic [XW-1:0]         col_x, row_x, col_p1, row_p1;
  logic [XW-1:0]         src_w, src_h, dst_w, dst_h, vis_w, vis_h;
  logic [XW-1:0]         off_x, off_y;

  assign col_x  = XW'(col_q);
  assign row_x  = XW'(row_q);
  assign col_p1 = col_x + XW'(1);
  assign row_p1 = row_x + XW'(1);
  assign src_w  = XW'(cfg_i.src_width);
  assign src_h  = XW'(cfg_i.src_height);
  assign dst_w  = XW'(cfg_i.dst_width);
  assign dst_h  = XW'(cfg_i.dst_height);
  assign vis_w  = (src_w < dst_w) ? src_w : dst_w;
  assign vis_h  = (src_h < dst_h) ? src_h : dst_h;

  // center a smaller source inside the destination
  assign off_x = (dst_w > src_w) ? ((dst_w - src_w) >> 1) : '0;
  assign off_y = (dst_h > src_h) ? ((dst_h - src_h) >> 1) : '0;

  assign pos_o.visible = (col_x < vis_w) && (row_x < vis_h);
  assign pos_o.last    = (col_p1 == vis_w) && (row_p1 == vis_h);
  assign x_o           = col_x + off_x;
  assign y_o           = row_x + off_y;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_wr_i) begin
      col_d = '0;
      row_d = '0;
    end else if (step_i) begin
      if (col_p1 >= src_w) begin
        col_d = '0;
        row_d = (row_p1 >= src_h) ? '0 : row_p1[COORD_BITS-1:0];
      end else begin
        col_d = col_p1[COORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  `ASSERT_NEXT(a_cfg_clears_pos, cfg_wr_i, col_q == '0 && row_q == '0, "counters not cleared")

endmodule

`default_nettype wire

FILE: sv/pixel_format_blit_to_rgba.sv
// path: a visible pixel is registered in the first stage with the palette ram read, then in the
// output register after the address multiply; one item per cycle unless the output stalls
// clipped pixels and palette writes produce no result
// reset: registers go to rgba8888 1280x720 in and out, raster counters to zero
// reset also clears the palette valid bits at once, so every entry reads zero without a sweep
`default_nettype none
`include "assert_macros.svh"

module pixel_format_blit_to_rgba import pfb_pkg::*; #(
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
  parameter int COORD_BITS    = COORD_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire in_t                   in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_t                       out_data_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int XW = xy_width(COORD_BITS);
  localparam int PW = 2 * XW;

  cfg_t          cfg_q, cfg_d;
  logic          cfg_hit;
  logic          in_xfer, pix_xfer, pal_xfer;
  raster_t       pos;
  logic [XW-1:0] x, y;
  logic [31:0]   pal_color;

  logic          s1_valid_q, s1_valid_d;
  logic [XW-1:0] s1_x_q, s1_y_q;
  logic [31:0]   s1_data_q;
  logic          s1_last_q;

  logic          out_valid_q, out_valid_d;
  out_t          out_q;
  logic          out_free;
  logic [PW-1:0] addr_full;
  logic [31:0]   rgba;
  logic [15:0]   p565;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d   = cfg_q;
    cfg_hit = 1'b0;
    if (cfg_valid_i) begin
      cfg_hit = 1'b1;
      unique case (cfg_index_i)
        REG_PIXEL_MODE: cfg_d.pixel_mode = pix_mode_e'(cfg_data_i[1:0]);
        REG_SRC_WIDTH:  cfg_d.src_width  = cfg_data_i[CFG_DIM_W-1:0];
        REG_SRC_HEIGHT: cfg_d.src_height = cfg_data_i[CFG_DIM_W-1:0];
        REG_DST_WIDTH:  cfg_d.dst_width  = cfg_data_i[CFG_DIM_W-1:0];
        REG_DST_HEIGHT: cfg_d.dst_height = cfg_data_i[CFG_DIM_W-1:0];
        default:        cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_mode <= MODE_RGBA8888;
      cfg_q.src_width  <= 12'd1280;
      cfg_q.src_height <= 12'd720;
      cfg_q.dst_width  <= 12'd1280;
      cfg_q.dst_height <= 12'd720;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // input side
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign pix_xfer   = in_xfer && (in_data_i.op == OP_PIXEL);
  assign pal_xfer   = in_xfer && (in_data_i.op == OP_PAL_WR);

  pfb_raster #(
    .COORD_BITS (COORD_BITS)
  ) u_raster (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .cfg_wr_i (cfg_hit),
    .step_i   (pix_xfer),
    .pos_o    (pos),
    .x_o      (x),
    .y_o      (y)
  );

  pfb_palette #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (pal_xfer),
    .wr_index_i (in_data_i.palette_index),
    .wr_color_i (in_data_i.palette_color),
    .rd_en_i    (pix_xfer),
    .rd_index_i (in_data_i.pixel_data[PAL_INDEX_W-1:0]),
    .color_o    (pal_color)
  );

  // first stage: visible pixels only
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (pix_xfer && pos.visible) begin
      s1_valid_d = 1'b1;
    end else if (out_free) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_xfer && pos.visible) begin
      s1_x_q    <= x;
      s1_y_q    <= y;
      s1_data_q <= in_data_i.pixel_data;
      s1_last_q <= pos.last;
    end
  end

  // second stage: address and color
  assign addr_full = (PW'(s1_y_q) * PW'(cfg_q.dst_width)) + PW'(s1_x_q);
  assign p565      = s1_data_q[15:0];

  always_comb begin
    case (cfg_q.pixel_mode)
      MODE_PAL8:   rgba = pal_color;
      MODE_RGB565: rgba = {ALPHA_OPAQUE,
                           5'((p565 & RGB565_B_MASK)), 3'd0,
                           6'((p565 & RGB565_G_MASK) >> 5), 2'd0,
                           5'((p565 & RGB565_R_MASK) >> 11), 3'd0};
      MODE_RGB888: rgba = {ALPHA_OPAQUE, s1_data_q[23:0]};
      default:     rgba = s1_data_q;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && out_free) begin
      out_q.dest_addr  <= addr_full[ADDR_W-1:0];
      out_q.rgba_color <= rgba;
      out_q.frame_last <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_NEXT(a_s1_moves, s1_valid_q && out_free, out_valid_q, "staged pixel did not reach output")
  `ASSERT_NEXT(a_vis_staged, pix_xfer && pos.visible, s1_valid_q, "visible pixel not staged")
  `ASSERT_RST(a_no_overrun, s1_valid_q && !out_free |-> !in_ready_o, "accept while stage blocked")

endmodule

`default_nettype wire

FILE: sim/tb_pixel_format_blit_to_rgba.sv
// self-checking testbench of the pixel format blitter: directed cases, then random frames
`timescale 1ns / 100ps

module tb_pixel_format_blit_to_rgba import pfb_pkg::*; ();

  localparam int CLK_HALF = 5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state
  logic [31:0] pal_shadow [256];
  logic [11:0] col_pos;
  logic [11:0] row_pos;
  cfg_t        cfg_shadow;
  out_t        rgba_expect_q [$];
  int unsigned mismatch_cnt = 0;
  bit          idle_en = 1'b1;
  logic [7:0]  pal_base = '0;

  pixel_format_blit_to_rgba DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #CLK_HALF clk_i = ~clk_i;

  function automatic int unsigned half_excess(int unsigned dst, int unsigned src);
    return (dst > src) ? (dst - src) / 2 : 0;
  endfunction

  // converts one accepted item, pixels also step the raster; returns 1 when a pixel lands
  function automatic bit predict_blit(in_t it, output out_t res);
    int unsigned col, row, sw, sh, dw, dh, vis_w, vis_h;
    logic [15:0] p565;
    bit hit;
    res = '0;
    if (it.op == OP_PAL_WR) begin
      pal_shadow[it.palette_index] = {ALPHA_OPAQUE, it.palette_color};
      return 1'b0;
    end
    col = 32'(col_pos);
    row = 32'(row_pos);
    sw = 32'(cfg_shadow.src_width);
    sh = 32'(cfg_shadow.src_height);
    dw = 32'(cfg_shadow.dst_width);
    dh = 32'(cfg_shadow.dst_height);
    vis_w = (sw < dw) ? sw : dw;
    vis_h = (sh < dh) ? sh : dh;
    hit = (col < vis_w) && (row < vis_h);
    if (hit) begin
      res.dest_addr = ADDR_W'((row + half_excess(dh, sh)) * dw + col + half_excess(dw, sw));
      p565 = it.pixel_data[15:0];
      case (cfg_shadow.pixel_mode)
        MODE_PAL8: res.rgba_color = pal_shadow[it.pixel_data[7:0]];
        MODE_RGB565: begin
          // no bit replication, low bits of each channel stay zero
          res.rgba_color = {ALPHA_OPAQUE, 8'((p565 & RGB565_B_MASK) << 3),
                            8'((p565 & RGB565_G_MASK) >> 3), 8'((p565 & RGB565_R_MASK) >> 8)};
        end
        MODE_RGB888: res.rgba_color = {ALPHA_OPAQUE, it.pixel_data[23:0]};
        default: res.rgba_color = it.pixel_data;
      endcase
      res.frame_last = (col + 1 == vis_w) && (row + 1 == vis_h);
    end
    if (col + 1 >= sw) begin
      col_pos = '0;
      row_pos = (row + 1 >= sh) ? 12'd0 : 12'(row + 1);
    end else begin
      col_pos = 12'(col + 1);
    end
    return hit;
  endfunction

  // tracks config and input transfers, checks every output transfer
  always @(posedge clk_i) begin
    out_t want;
    out_t got;
    if (!rst_ni) begin
      for (int i = 0; i < 256; i++) pal_shadow[i[7:0]] = '0;
      col_pos = '0;
      row_pos = '0;
      cfg_shadow.pixel_mode = MODE_RGBA8888;
      cfg_shadow.src_width = 12'd1280;
      cfg_shadow.src_height = 12'd720;
      cfg_shadow.dst_width = 12'd1280;
      cfg_shadow.dst_height = 12'd720;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PIXEL_MODE: cfg_shadow.pixel_mode = pix_mode_e'(cfg_data[1:0]);
          REG_SRC_WIDTH:  cfg_shadow.src_width = cfg_data;
          REG_SRC_HEIGHT: cfg_shadow.src_height = cfg_data;
          REG_DST_WIDTH:  cfg_shadow.dst_width = cfg_data;
          REG_DST_HEIGHT: cfg_shadow.dst_height = cfg_data;
          default: ;
        endcase
        if (cfg_index <= REG_DST_HEIGHT) begin
          col_pos = '0;
          row_pos = '0;
        end
      end
      if (in_valid && in_ready) begin
        if (predict_blit(in_data, want)) rgba_expect_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = out_data;
        if (rgba_expect_q.size() == 0) begin
          $error("unexpected result: dest_addr %0h rgba_color %0h", got.dest_addr, got.rgba_color);
          mismatch_cnt++;
        end else begin
          want = rgba_expect_q.pop_front();
          if (got.dest_addr !== want.dest_addr) begin
            $error("dest_addr: expected %0h, got %0h", want.dest_addr, got.dest_addr);
            mismatch_cnt++;
          end
          if (got.rgba_color !== want.rgba_color) begin
            $error("rgba_color: expected %0h, got %0h", want.rgba_color, got.rgba_color);
            mismatch_cnt++;
          end
          if (got.frame_last !== want.frame_last) begin
            $error("frame_last: expected %0b, got %0b", want.frame_last, got.frame_last);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  // receiver stalls in random bursts
  always @(posedge clk_i) begin
    if (idle_en && $urandom_range(0, 9) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    out_ready <= 1'b1;
  end

  task automatic send_item(in_t it);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic wait_blit_idle();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (rgba_expect_q.size() != 0);
    // clipped pixels leave nothing to wait for, so cover the pipeline depth
    repeat (4) @(posedge clk_i);
  endtask

  // leaves cfg_valid high; the caller lowers it after its last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  task automatic set_frame(pix_mode_e mode, logic [11:0] sw, logic [11:0] sh,
                           logic [11:0] dw, logic [11:0] dh);
    wait_blit_idle();
    write_reg(REG_PIXEL_MODE, 12'(mode));
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_DST_WIDTH, dw);
    write_reg(REG_DST_HEIGHT, dh);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_t pixel_item(logic [31:0] data);
    in_t it;
    it.op = OP_PIXEL;
    it.pixel_data = data;
    it.palette_index = 8'($urandom);
    it.palette_color = 24'($urandom);
    return it;
  endfunction

  function automatic in_t pal_item(logic [7:0] idx, logic [23:0] color);
    in_t it;
    it.op = OP_PAL_WR;
    it.pixel_data = $urandom;
    it.palette_index = idx;
    it.palette_color = color;
    return it;
  endfunction

  function automatic logic [11:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return 12'd4095;
      1: return 12'd1;
      2, 3: return 12'($urandom_range(9, 48));
      default: return 12'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_item(pixel_item(32'h0000_0000));
    send_item(pixel_item(32'hffff_ffff));
  endtask

  task automatic test_unwritten_palette();
    set_frame(MODE_PAL8, 12'd4, 12'd4, 12'd4, 12'd4);
    send_item(pixel_item(32'h0000_0000));
    send_item(pixel_item(32'hffff_ffff));
  endtask

  task automatic test_formats();
    send_item(pal_item(8'h00, 24'hffffff));
    send_item(pal_item(8'hff, 24'h000000));
    send_item(pixel_item(32'hffff_ff00));
    send_item(pixel_item(32'h0000_00ff));
    set_frame(MODE_RGB565, 12'd4, 12'd4, 12'd4, 12'd4);
    send_item(pixel_item(32'h0000_ffff));
    send_item(pixel_item(32'hffff_0000));
    set_frame(MODE_RGB888, 12'd4, 12'd4, 12'd4, 12'd4);
    send_item(pixel_item(32'h00ff_ffff));
    send_item(pixel_item(32'hff00_0000));
  endtask

  task automatic test_clip_and_center();
    // source larger than destination: right column and bottom row clipped
    set_frame(MODE_RGBA8888, 12'd3, 12'd2, 12'd2, 12'd1);
    repeat (6) send_item(pixel_item($urandom));
    // single pixel centered in the largest destination
    set_frame(MODE_RGB888, 12'd1, 12'd1, 12'd4095, 12'd4095);
    send_item(pixel_item($urandom));
  endtask

  task automatic test_zero_sizes();
    set_frame(MODE_RGBA8888, 12'd4, 12'd4, 12'd0, 12'd4);
    send_item(pixel_item($urandom));
    set_frame(MODE_RGBA8888, 12'd0, 12'd4, 12'd4, 12'd4);
    send_item(pixel_item($urandom));
    set_frame(MODE_RGBA8888, 12'd4, 12'd0, 12'd4, 12'd4);
    send_item(pixel_item($urandom));
  endtask

  task automatic test_cfg_clears_counters();
    set_frame(MODE_RGBA8888, 12'd4, 12'd4, 12'd4, 12'd4);
    send_item(pixel_item($urandom));
    send_item(pixel_item($urandom));
    // a write past the register list must leave the raster position alone
    wait_blit_idle();
    write_reg(REG_UNUSED, 12'hfff);
    cfg_valid <= 1'b0;
    send_item(pixel_item($urandom));
    wait_blit_idle();
    write_reg(REG_PIXEL_MODE, 12'(MODE_RGBA8888));
    cfg_valid <= 1'b0;
    send_item(pixel_item($urandom));
  endtask

  task automatic test_random_frames(int unsigned n_items, int unsigned calm_from);
    int unsigned sent;
    int unsigned len;
    int unsigned frame_px;
    int unsigned phase;
    logic [11:0] sw, sh, dw, dh;
    pix_mode_e mode;
    in_t it;
    bit pal_wr;
    sent = 0;
    phase = 0;
    while (sent < n_items) begin
      idle_en = (sent < calm_from) && ($urandom_range(0, 3) != 0);
      mode = pix_mode_e'($urandom_range(0, 3));
      sw = pick_dim();
      sh = pick_dim();
      dw = pick_dim();
      dh = pick_dim();
      set_frame(mode, sw, sh, dw, dh);
      pal_base = 8'($urandom);
      frame_px = 32'(sw) * 32'(sh);
      // small frames run whole, one to three times over, to reach the frame end
      len = (frame_px <= 40) ? frame_px * $urandom_range(1, 3) + $urandom_range(0, 5)
                             : $urandom_range(20, 80);
      for (int i = 0; i < len; i++) begin
        pal_wr = (mode == MODE_PAL8 && i < 6) ? 1'b1 : ($urandom_range(0, 7) == 0);
        it.op = pal_wr ? OP_PAL_WR : OP_PIXEL;
        it.pixel_data = $urandom;
        it.palette_index = 8'($urandom);
        it.palette_color = 24'($urandom);
        // keep lookups mostly on a small window of written entries
        if ($urandom_range(0, 4) != 0) begin
          it.palette_index = pal_base + 8'($urandom_range(0, 15));
          it.pixel_data[7:0] = pal_base + 8'($urandom_range(0, 15));
        end
        send_item(it);
        if (i == len / 2 && phase % 4 == 0) wait_blit_idle();
      end
      sent += len;
      phase++;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_unwritten_palette();
    test_formats();
    test_clip_and_center();
    test_zero_sizes();
    test_cfg_clears_counters();
    test_random_frames(1150, 1020);
    wait_blit_idle();
    repeat (16) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb_pixel_format_blit_to_rgba: PASS");
    end else begin
      $display("tb_pixel_format_blit_to_rgba: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_pixel_format_blit_to_rgba: FAIL");
    $finish;
  end

endmodule
